### hw/rtl/mtb_pkg.sv
// package for the manchester transmitter with backoff
// holds transaction payload types, item kind codes, status codes and constants
// no dependencies
package mtb_pkg;

    localparam int unsigned DelayWidth = 22;

    typedef struct packed {
        logic [2:0]            kind;
        logic [7:0]            data_byte;
        logic                  first_of_message;
        logic [DelayWidth-1:0] random_delay;
        logic                  channel_idle;
    } t_in;

    typedef struct packed {
        logic       line_level;
        logic [1:0] tx_status;
        logic       load_accepted;
        logic       backoff_active;
        logic       message_finished;
    } t_out;

    // item kinds
    localparam logic [2:0] KindLoad       = 3'd0;
    localparam logic [2:0] KindStart      = 3'd1;
    localparam logic [2:0] KindPause      = 3'd2;
    localparam logic [2:0] KindResume     = 3'd3;
    localparam logic [2:0] KindHalfTick   = 3'd4;
    localparam logic [2:0] KindBackoffTick = 3'd5;

    // transmitter status
    localparam logic [1:0] StDone    = 2'd0;
    localparam logic [1:0] StSending = 2'd1;
    localparam logic [1:0] StPaused  = 2'd2;

    localparam logic [7:0]            NewlineByte = 8'h0A;
    localparam logic [DelayWidth-1:0] MaxDelay    = 22'd2999999;
    localparam logic [3:0]            BitsPerByte = 4'd8;

endpackage

### hw/rtl/manchester_transmitter_backoff.sv
// manchester transmitter with pause and random backoff, top level
// depends on mtb_pkg, mtb_core (with mtb_ram) and mtb_skid
//
// input channel i_in_valid/o_in_ready carries one item per transaction: a byte
// load, start, pause, resume, half-bit tick or backoff tick. every accepted item
// produces exactly one result transaction on o_out_valid/i_out_ready with the
// line level, transmitter status, load acceptance, backoff activity and the
// message-finished pulse as they stand after that item.
// one item is accepted per cycle while o_in_ready is high; each result is registered in the output stage.
// the message byte for the next half-bit tick is prefetched from the buffer ram
// ahead of the tick, so the ram's registered read adds no latency.
// a two-entry output stage lets the block take a new item while a result waits;
// when both entries are full o_in_ready drops until the receiver takes one.
// reset (synchronous, active low) leaves the line high, status done, no backoff
// running and an empty message; buffer contents are kept and are only valid
// once written by loads.
module manchester_transmitter_backoff #(
    parameter int unsigned BUFFER_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mtb_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mtb_pkg::t_out o_out_data
);

    logic          take;
    mtb_pkg::t_out result;

    assign take = i_in_valid && o_in_ready;

    mtb_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (i_in_data),
        .o_result (result)
    );

    mtb_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (take),
        .i_data      (result),
        .o_ready     (o_in_ready),
        .o_valid     (o_out_valid),
        .i_pop_ready (i_out_ready),
        .o_data      (o_out_data)
    );

endmodule

### hw/rtl/mtb_ram.sv
// generic single write port ram with registered read
// no dependencies
module mtb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mtb_core.sv
// transmitter state and per-transaction next-state logic
// depends on mtb_pkg and mtb_ram (message buffer)
module mtb_core #(
    parameter int unsigned BUFFER_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  mtb_pkg::t_in  i_item,
    output mtb_pkg::t_out o_result
);

    localparam int unsigned PW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned DW = mtb_pkg::DelayWidth;
    localparam logic [PW-1:0] DepthVal = PW'(BUFFER_DEPTH);
    localparam logic [2:0]    MsbIdx   = 3'd7;

    logic [PW-1:0] r_length, n_length;
    logic [PW-1:0] r_byte_pos, n_byte_pos;
    logic [3:0]    r_bit_pos, n_bit_pos;
    logic          r_first_half, n_first_half;
    logic          r_line, n_line;
    logic [1:0]    r_status, n_status;
    logic [DW-1:0] r_backoff_count, n_backoff_count;
    logic          r_backoff_running, n_backoff_running;

    logic          accepted;
    logic          finished;
    logic          we;
    logic [AW-1:0] waddr;
    logic [PW-1:0] len_base;
    logic [PW-1:0] byte_t;
    logic [3:0]    bit_t;
    logic [DW-1:0] delay_sat;
    logic [DW-1:0] count_dec;
    logic [PW-1:0] rd_pos;
    logic [7:0]    rdata;

    always_comb begin
        n_length          = r_length;
        n_byte_pos        = r_byte_pos;
        n_bit_pos         = r_bit_pos;
        n_first_half      = r_first_half;
        n_line            = r_line;
        n_status          = r_status;
        n_backoff_count   = r_backoff_count;
        n_backoff_running = r_backoff_running;
        accepted          = 1'b0;
        finished          = 1'b0;
        we                = 1'b0;
        len_base          = i_item.first_of_message ? '0 : r_length;
        waddr             = len_base[AW-1:0];
        byte_t            = (r_bit_pos >= mtb_pkg::BitsPerByte) ? r_byte_pos + 1'b1 : r_byte_pos;
        bit_t             = (r_bit_pos >= mtb_pkg::BitsPerByte) ? 4'd0 : r_bit_pos;
        delay_sat         = (i_item.random_delay > mtb_pkg::MaxDelay) ? mtb_pkg::MaxDelay
                                                                     : i_item.random_delay;
        count_dec         = r_backoff_count - 1'b1;
        if (i_take) begin
            unique case (i_item.kind)
                mtb_pkg::KindLoad: begin
                    if (r_status == mtb_pkg::StDone) begin
                        n_length = len_base;
                        if (len_base < DepthVal) begin
                            we       = 1'b1;
                            n_length = len_base + 1'b1;
                            accepted = 1'b1;
                        end
                    end
                end
                mtb_pkg::KindStart: begin
                    if (i_item.channel_idle) begin
                        if (r_status == mtb_pkg::StDone) begin
                            n_first_half = 1'b1;
                            n_byte_pos   = '0;
                            n_bit_pos    = '0;
                        end
                        n_status = mtb_pkg::StSending;
                    end else begin
                        n_status     = mtb_pkg::StPaused;
                        n_first_half = 1'b1;
                        n_byte_pos   = '0;
                        n_bit_pos    = '0;
                    end
                end
                mtb_pkg::KindPause: begin
                    if (r_status == mtb_pkg::StSending) begin
                        n_status = mtb_pkg::StPaused;
                    end
                end
                mtb_pkg::KindResume: begin
                    if (r_status == mtb_pkg::StPaused) begin
                        n_backoff_count   = delay_sat + 1'b1;
                        n_backoff_running = 1'b1;
                    end
                end
                mtb_pkg::KindHalfTick: begin
                    if (r_status == mtb_pkg::StSending) begin
                        if (r_first_half) begin
                            n_byte_pos = byte_t;
                            n_bit_pos  = bit_t;
                            // rdata was prefetched for byte_t on the previous cycle
                            if (byte_t < r_length && rdata != mtb_pkg::NewlineByte) begin
                                n_bit_pos = bit_t + 1'b1;
                                n_line    = ~rdata[MsbIdx - bit_t[2:0]];
                            end else begin
                                n_line   = 1'b1;
                                n_status = mtb_pkg::StDone;
                                finished = 1'b1;
                            end
                            n_first_half = 1'b0;
                        end else begin
                            n_line       = ~r_line;
                            n_first_half = 1'b1;
                        end
                    end
                end
                mtb_pkg::KindBackoffTick: begin
                    if (r_backoff_running) begin
                        n_backoff_count = count_dec;
                        if (count_dec == '0) begin
                            n_backoff_running = 1'b0;
                            if (i_item.channel_idle) begin
                                if (r_status == mtb_pkg::StDone) begin
                                    n_first_half = 1'b1;
                                    n_byte_pos   = '0;
                                    n_bit_pos    = '0;
                                end
                                n_status = mtb_pkg::StSending;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // prefetch the byte the next half-bit tick would read
    assign rd_pos = (n_bit_pos >= mtb_pkg::BitsPerByte) ? n_byte_pos + 1'b1 : n_byte_pos;

    mtb_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_item.data_byte),
        .i_raddr (rd_pos[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length          <= '0;
            r_byte_pos        <= '0;
            r_bit_pos         <= '0;
            r_first_half      <= 1'b1;
            r_line            <= 1'b1;
            r_status          <= mtb_pkg::StDone;
            r_backoff_count   <= '0;
            r_backoff_running <= 1'b0;
        end else begin
            r_length          <= n_length;
            r_byte_pos        <= n_byte_pos;
            r_bit_pos         <= n_bit_pos;
            r_first_half      <= n_first_half;
            r_line            <= n_line;
            r_status          <= n_status;
            r_backoff_count   <= n_backoff_count;
            r_backoff_running <= n_backoff_running;
        end
    end

    assign o_result.line_level       = n_line;
    assign o_result.tx_status        = n_status;
    assign o_result.load_accepted    = accepted;
    assign o_result.backoff_active   = n_backoff_running;
    assign o_result.message_finished = finished;

    a_backoff_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_backoff_running |-> r_backoff_count != '0)
        else $error("backoff running with zero count");

    a_done_line_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status == mtb_pkg::StDone |-> r_line)
        else $error("line not idle high while done");

    a_finish_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finished |=> r_status == mtb_pkg::StDone && r_first_half == 1'b0)
        else $error("message end did not leave transmitter done");

    a_bit_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_pos <= mtb_pkg::BitsPerByte)
        else $error("bit position past end of byte");

endmodule

### hw/rtl/mtb_skid.sv
// two-entry output stage: result register plus skid register
// depends on mtb_pkg
module mtb_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mtb_pkg::t_out i_data,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_pop_ready,
    output mtb_pkg::t_out o_data
);

    logic          r_main_valid, n_main_valid;
    logic          r_skid_valid, n_skid_valid;
    mtb_pkg::t_out r_main, n_main;
    mtb_pkg::t_out r_skid, n_skid;
    logic          pop;

    assign pop = r_main_valid && i_pop_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (pop) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without main entry");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("transaction pushed into full output stage");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && pop |=> r_main_valid && r_main == $past(r_skid))
        else $error("skid entry lost on pop");

endmodule

### tb/manchester_transmitter_backoff_tb.sv
// self-checking testbench for manchester_transmitter_backoff
// predicts every result transaction in a scoreboard class and compares field by field
// depends on mtb_pkg and the manchester_transmitter_backoff rtl
module manchester_transmitter_backoff_tb;
    import mtb_pkg::*;

    localparam int BufDepth      = 256;
    localparam int RandomItems   = 1150;
    localparam int StopPos       = 24;
    localparam int HoldCycles    = 120;
    localparam int TimeoutCycles = 1_000_000;
    localparam int MaxReports    = 40;

    // kinds the block has no use for
    localparam logic [2:0] KindSpare0 = 3'd6;
    localparam logic [2:0] KindSpare1 = 3'd7;

    class manchester_scoreboard;
        logic [7:0]            msg_mem [BufDepth];
        logic [8:0]            msg_len;
        logic [8:0]            byte_pos;
        logic [3:0]            bit_pos;
        logic                  first_half;
        logic                  line;
        logic [1:0]            status;
        logic [DelayWidth-1:0] backoff_cnt;
        logic                  backoff_on;
        t_out                  expected_results[$];
        int                    errors;

        function new();
            msg_len     = '0;
            byte_pos    = '0;
            bit_pos     = '0;
            first_half  = 1'b1;
            line        = 1'b1;
            status      = StDone;
            backoff_cnt = '0;
            backoff_on  = 1'b0;
            errors      = 0;
        endfunction

        function void rewind();
            first_half = 1'b1;
            byte_pos   = '0;
            bit_pos    = '0;
        endfunction

        function void try_start(logic idle);
            if (idle) begin
                if (status == StDone) rewind();
                status = StSending;
            end else begin
                status = StPaused;
                rewind();
            end
        endfunction

        // returns 1 when this tick ends the message
        function logic half_tick();
            logic [7:0] cur;
            logic       ended;
            ended = 1'b0;
            if (status != StSending) return 1'b0;
            if (first_half) begin
                if (bit_pos >= BitsPerByte) begin
                    bit_pos  = '0;
                    byte_pos = byte_pos + 9'd1;
                end
                cur = (byte_pos < msg_len) ? msg_mem[byte_pos[7:0]] : NewlineByte;
                if (cur != NewlineByte) begin
                    // msb first, a one bit starts low
                    line    = ~cur[3'd7 - bit_pos[2:0]];
                    bit_pos = bit_pos + 4'd1;
                end else begin
                    line   = 1'b1;
                    status = StDone;
                    ended  = 1'b1;
                end
                first_half = 1'b0;
            end else begin
                line       = ~line;
                first_half = 1'b1;
            end
            return ended;
        endfunction

        function void note_item(t_in it);
            t_out                  r;
            logic [DelayWidth-1:0] d;
            r = '0;
            case (it.kind)
                KindLoad: begin
                    if (status == StDone) begin
                        if (it.first_of_message) msg_len = '0;
                        if (msg_len < BufDepth) begin
                            msg_mem[msg_len[7:0]] = it.data_byte;
                            msg_len = msg_len + 9'd1;
                            r.load_accepted = 1'b1;
                        end
                    end
                end
                KindStart: try_start(it.channel_idle);
                KindPause: begin
                    if (status == StSending) status = StPaused;
                end
                KindResume: begin
                    if (status == StPaused) begin
                        d = (it.random_delay > MaxDelay) ? MaxDelay : it.random_delay;
                        backoff_cnt = d + 1'b1;
                        backoff_on  = 1'b1;
                    end
                end
                KindHalfTick: r.message_finished = half_tick();
                KindBackoffTick: begin
                    if (backoff_on) begin
                        backoff_cnt = backoff_cnt - 1'b1;
                        if (backoff_cnt == '0) begin
                            backoff_on = 1'b0;
                            if (it.channel_idle) try_start(1'b1);
                        end
                    end
                end
                default: ;
            endcase
            r.line_level     = line;
            r.tx_status      = status;
            r.backoff_active = backoff_on;
            expected_results.push_back(r);
        endfunction

        function void mismatch(string field, logic [1:0] want, logic [1:0] got);
            if (errors < MaxReports)
                $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_results.size() == 0) begin
                if (errors < MaxReports) $error("result transaction with nothing expected");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.line_level !== want.line_level)
                mismatch("line_level", want.line_level, got.line_level);
            if (got.tx_status !== want.tx_status)
                mismatch("tx_status", want.tx_status, got.tx_status);
            if (got.load_accepted !== want.load_accepted)
                mismatch("load_accepted", want.load_accepted, got.load_accepted);
            if (got.backoff_active !== want.backoff_active)
                mismatch("backoff_active", want.backoff_active, got.backoff_active);
            if (got.message_finished !== want.message_finished)
                mismatch("message_finished", want.message_finished, got.message_finished);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out_data;

    manchester_scoreboard sb;
    logic hold_req;
    int   burst_left;
    int   random_count;

    manchester_transmitter_backoff #(
        .BUFFER_DEPTH(BufDepth)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_in mk(logic [2:0] kind, logic [7:0] data, logic first,
                               logic [DelayWidth-1:0] delay, logic idle);
        t_in it;
        it.kind             = kind;
        it.data_byte        = data;
        it.first_of_message = first;
        it.random_delay     = delay;
        it.channel_idle     = idle;
        return it;
    endfunction

    function automatic t_in rand_item(logic [2:0] kind);
        return mk(kind, 8'($urandom), 1'($urandom), DelayWidth'($urandom), 1'($urandom));
    endfunction

    function automatic logic [DelayWidth-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return DelayWidth'($urandom_range(0, 3));
        if (r < 18) return DelayWidth'($urandom_range(4, 30));
        return DelayWidth'($urandom);
    endfunction

    // called just after a falling edge, returns just after a falling edge
    task automatic send_item(t_in it);
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        i_in_data  = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic run_to_end();
        while (sb.status == StSending) send_item(rand_item(KindHalfTick));
    endtask

    task automatic step_item();
        t_in it;
        int  r;
        r = $urandom_range(0, 99);
        if (sb.status == StPaused) begin
            if (r < 40) begin
                it = rand_item(KindBackoffTick);
                it.channel_idle = ($urandom_range(0, 3) != 0);
            end else if (r < 65) begin
                it = rand_item(KindResume);
                it.random_delay = pick_delay();
            end else if (r < 80) begin
                it = rand_item(KindStart);
            end else if (r < 92) begin
                it = rand_item(KindHalfTick);
            end else begin
                it = rand_item(3'($urandom_range(0, 7)));
            end
        end else begin
            if (r < 82) begin
                it = rand_item(KindHalfTick);
            end else if (r < 86) begin
                it = rand_item(KindPause);
            end else if (r < 89) begin
                it = rand_item(KindStart);
                it.channel_idle = ($urandom_range(0, 4) != 0);
            end else if (r < 93) begin
                it = rand_item(KindBackoffTick);
            end else if (r < 96) begin
                it = rand_item(KindResume);
                it.random_delay = pick_delay();
            end else begin
                it = rand_item(3'($urandom_range(0, 7)));
            end
        end
        send_item(it);
    endtask

    // load a short message, start it and keep it moving with ticks and control items
    task automatic run_message();
        t_in it;
        int  len;
        int  steps;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
            it = rand_item(KindLoad);
            it.first_of_message = (i == 0) || ($urandom_range(0, 30) == 0);
            if ($urandom_range(0, 9) == 0) it.data_byte = NewlineByte;
            send_item(it);
            random_count++;
        end
        it = rand_item(KindStart);
        it.channel_idle = ($urandom_range(0, 3) != 0);
        send_item(it);
        random_count++;
        steps = 0;
        while (sb.status != StDone && steps < 600) begin
            step_item();
            steps++;
            random_count++;
        end
        repeat ($urandom_range(0, 2)) send_item(rand_item(3'($urandom_range(0, 7))));
    endtask

    // 256 bytes with one newline early on, two loads past the end, then send up to the newline
    task automatic fill_buffer();
        t_in it;
        for (int i = 0; i < BufDepth + 2; i++) begin
            it = rand_item(KindLoad);
            it.first_of_message = (i == 0);
            if (it.data_byte == NewlineByte) it.data_byte = ~NewlineByte;
            if (i == StopPos) it.data_byte = NewlineByte;
            send_item(it);
        end
        it = rand_item(KindStart);
        it.channel_idle = 1'b1;
        send_item(it);
        run_to_end();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    // receiver: stall patterns that change every so often, plus long hold-offs on request
    initial begin
        int mode;
        int left;
        mode        = 0;
        left        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HoldCycles - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(10, 150);
                end
                left--;
                case (mode)
                    0: i_out_ready = 1'b1;
                    1: i_out_ready = 1'($urandom);
                    2: i_out_ready = ($urandom_range(0, 3) == 0);
                    default: i_out_ready = (left % 3 == 0);
                endcase
            end
        end
    end

    initial begin
        #(TimeoutCycles * 10);
        $display("manchester_transmitter_backoff_tb NOT OK");
        $finish;
    end

    initial begin
        sb           = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        hold_req     = 1'b0;
        burst_left   = 0;
        random_count = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // control items with nothing to act on
        send_item(mk(KindHalfTick, 8'h00, 1'b0, '0, 1'b0));
        send_item(mk(KindBackoffTick, 8'h00, 1'b0, '0, 1'b1));
        send_item(mk(KindSpare0, 8'hFF, 1'b1, '1, 1'b1));
        send_item(mk(KindSpare1, 8'hFF, 1'b1, '1, 1'b1));
        send_item(mk(KindPause, 8'h00, 1'b0, '0, 1'b1));
        send_item(mk(KindResume, 8'h00, 1'b0, '1, 1'b1));
        // message that stops at the newline
        send_item(mk(KindLoad, 8'hFF, 1'b1, '0, 1'b0));
        send_item(mk(KindLoad, 8'h00, 1'b0, '1, 1'b1));
        send_item(mk(KindLoad, NewlineByte, 1'b0, '0, 1'b0));
        send_item(mk(KindLoad, 8'h5A, 1'b0, '0, 1'b0));
        // busy channel pauses, loads are refused while paused
        send_item(mk(KindStart, 8'h00, 1'b0, '0, 1'b0));
        send_item(mk(KindLoad, 8'h33, 1'b1, '0, 1'b1));
        // saturating delays, then a reload that expires on a busy channel
        send_item(mk(KindResume, 8'h00, 1'b0, '1, 1'b0));
        send_item(mk(KindResume, 8'h00, 1'b0, MaxDelay + 1'b1, 1'b0));
        send_item(mk(KindResume, 8'h00, 1'b0, '0, 1'b0));
        send_item(mk(KindBackoffTick, 8'h00, 1'b0, '0, 1'b0));
        // backoff expiry on an idle channel restarts sending
        send_item(mk(KindResume, 8'h00, 1'b0, 22'd1, 1'b0));
        send_item(mk(KindBackoffTick, 8'h00, 1'b0, '0, 1'b1));
        send_item(mk(KindBackoffTick, 8'h00, 1'b0, '0, 1'b1));
        repeat (4) send_item(mk(KindHalfTick, 8'h00, 1'b0, '0, 1'b1));
        send_item(mk(KindPause, 8'h00, 1'b0, '0, 1'b1));
        send_item(mk(KindHalfTick, 8'h00, 1'b0, '0, 1'b1));
        send_item(mk(KindStart, 8'h00, 1'b0, '0, 1'b1));
        send_item(mk(KindResume, 8'h00, 1'b0, 22'd5, 1'b1));
        send_item(mk(KindStart, 8'h00, 1'b0, '0, 1'b0));
        send_item(mk(KindStart, 8'h00, 1'b0, '0, 1'b1));
        run_to_end();
        drain();

        fill_buffer();
        drain();

        for (int seq = 0; random_count < RandomItems; seq++) begin
            if (seq % 6 == 5) drain();
            if (seq % 9 == 2) hold_req = 1'b1;
            run_message();
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("manchester_transmitter_backoff_tb OK");
        end else begin
            $display("manchester_transmitter_backoff_tb NOT OK");
        end
        $finish;
    end

endmodule

### manchester_transmitter_backoff.f
hw/rtl/mtb_pkg.sv
hw/rtl/mtb_ram.sv
hw/rtl/mtb_core.sv
hw/rtl/mtb_skid.sv
hw/rtl/manchester_transmitter_backoff.sv
tb/manchester_transmitter_backoff_tb.sv
